### hw/rtl/omrc_pkg.sv
package omrc_pkg;

   // Store size and stored key width.
   localparam int CAPACITY    = 1024;
   localparam int VALUE_WIDTH = 32;

   // Widths fixed by the item formats.
   localparam int FUNC_WIDTH     = 2;
   localparam int IN_VALUE_WIDTH = 32;
   localparam int COUNT_WIDTH    = 11;
   localparam int STATUS_WIDTH   = 2;

   // Running counts inside the chain can reach CAPACITY itself.
   localparam int OCC_WIDTH = $clog2(CAPACITY + 1);

   // Operation codes.
   localparam logic [FUNC_WIDTH-1:0] FUNC_INSERT   = 2'd0;
   localparam logic [FUNC_WIDTH-1:0] FUNC_REMOVE   = 2'd1;
   localparam logic [FUNC_WIDTH-1:0] FUNC_COUNT_LE = 2'd2;
   localparam logic [FUNC_WIDTH-1:0] FUNC_COUNT_GE = 2'd3;

   // Result status codes.
   localparam logic [STATUS_WIDTH-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL   = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_ABSENT = 2'd2;

   typedef logic signed [VALUE_WIDTH-1:0] key_type;
   typedef logic [OCC_WIDTH-1:0]          occ_type;

   // Request item as it arrives on the input channel.
   typedef struct packed {
      logic [FUNC_WIDTH-1:0]            func;
      logic signed [IN_VALUE_WIDTH-1:0] value;
   } req_type;

   // Result item on the output channel.
   typedef struct packed {
      logic [COUNT_WIDTH-1:0]  count;
      logic [STATUS_WIDTH-1:0] status;
   } rsp_type;

   // Item travelling along the chain of cells.
   typedef struct packed {
      logic                  valid;
      logic [FUNC_WIDTH-1:0] func;
      key_type               key;
      occ_type               count;
      logic                  hit;
   } stage_type;

endpackage

### hw/rtl/omrc_cell.sv
module omrc_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  omrc_pkg::stage_type up_stage,
   output omrc_pkg::stage_type down_stage
);
   import omrc_pkg::*;

   logic      used_ff;
   logic      used_in;
   key_type   entry_ff;
   key_type   entry_in;
   stage_type stage_ff;
   stage_type stage_in;

   // Apply the passing item to the entry held in this cell.
   always_comb begin
      used_in  = used_ff;
      entry_in = entry_ff;
      stage_in = up_stage;
      if (up_stage.valid) begin
         case (up_stage.func)
            FUNC_INSERT: begin
               // The first free cell along the chain takes the new value.
               if (!up_stage.hit && !used_ff) begin
                  used_in      = 1'b1;
                  entry_in     = up_stage.key;
                  stage_in.hit = 1'b1;
               end
            end
            FUNC_REMOVE: begin
               // The first matching cell along the chain gives up its copy.
               if (!up_stage.hit && used_ff && (entry_ff == up_stage.key)) begin
                  used_in      = 1'b0;
                  stage_in.hit = 1'b1;
               end
            end
            FUNC_COUNT_LE: begin
               if (used_ff && (entry_ff <= up_stage.key)) begin
                  stage_in.count = up_stage.count + OCC_WIDTH'(1);
               end
            end
            FUNC_COUNT_GE: begin
               if (used_ff && (entry_ff >= up_stage.key)) begin
                  stage_in.count = up_stage.count + OCC_WIDTH'(1);
               end
            end
            default: begin
               stage_in = up_stage;
            end
         endcase
      end
   end

   // Occupied flag and the item register towards the next cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= 1'b0;
         stage_ff <= '0;
      end else if (adv) begin
         used_ff  <= used_in;
         stage_ff <= stage_in;
      end
   end

   // Stored value; only read while the cell is occupied.
   always_ff @(posedge clock) begin
      if (adv) begin
         entry_ff <= entry_in;
      end
   end

   assign down_stage = stage_ff;

endmodule

### hw/rtl/omrc_tail.sv
module omrc_tail (
   input  logic                clock,
   input  logic                reset,
   input  omrc_pkg::stage_type tail_stage,
   input  logic                rsp_ready,
   output logic                adv,
   output logic                rsp_valid,
   output omrc_pkg::rsp_type   rsp_data,
   output omrc_pkg::occ_type   occ
);
   import omrc_pkg::*;

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;
   occ_type occ_ff;
   occ_type occ_in;

   // The chain moves whenever the output register is free or being emptied.
   assign adv = !rsp_valid_ff || rsp_ready;

   // Settle the outcome of an item that has passed every cell.
   always_comb begin
      occ_in             = occ_ff;
      rsp_data_in.status = STATUS_OK;
      rsp_data_in.count  = COUNT_WIDTH'(tail_stage.count);
      case (tail_stage.func)
         FUNC_INSERT: begin
            if (tail_stage.hit) begin
               occ_in = occ_ff + OCC_WIDTH'(1);
            end else begin
               rsp_data_in.status = STATUS_FULL;
            end
            rsp_data_in.count = COUNT_WIDTH'(occ_in);
         end
         FUNC_REMOVE: begin
            if (tail_stage.hit) begin
               occ_in = occ_ff - OCC_WIDTH'(1);
            end else begin
               rsp_data_in.status = STATUS_ABSENT;
            end
            rsp_data_in.count = COUNT_WIDTH'(occ_in);
         end
         default: begin
            rsp_data_in.count = COUNT_WIDTH'(tail_stage.count);
         end
      endcase
   end

   // Control state: output valid and occupancy.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         occ_ff       <= '0;
      end else if (adv) begin
         rsp_valid_ff <= tail_stage.valid;
         if (tail_stage.valid) begin
            occ_ff <= occ_in;
         end
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (adv && tail_stage.valid) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign occ       = occ_ff;

endmodule

### hw/rtl/ordered_multiset_rank_counter.sv
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  req_data  (func, value)
// rsp       out        rsp_valid/rsp_ready  rsp_data  (count, status)
//
// Each item walks the row of CAPACITY cells, one cell per cycle while the row
// moves, through each cell's register and then into the output register.
// Items follow one another, one accepted per cycle while the row moves.
// Reset clears every occupied flag, the row and the occupancy, and req_ready
// stays low while reset is high.
// While a result waits on rsp_ready the whole row holds and req_ready is low.
module ordered_multiset_rank_counter (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  omrc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output omrc_pkg::rsp_type rsp_data
);
   import omrc_pkg::*;

   logic      adv;
   occ_type   occ;
   stage_type link [0:CAPACITY];

   // The incoming item enters the first cell whenever the row moves.
   assign req_ready     = adv && !reset;
   assign link[0].valid = req_valid;
   assign link[0].func  = req_data.func;
   assign link[0].key   = VALUE_WIDTH'(req_data.value);
   assign link[0].count = '0;
   assign link[0].hit   = 1'b0;

   // Row of cells, one stored entry each.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      omrc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .adv        (adv),
         .up_stage   (link[i]),
         .down_stage (link[i+1])
      );
   end

   // Outcome, occupancy and output register.
   omrc_tail u_tail (
      .clock      (clock),
      .reset      (reset),
      .tail_stage (link[CAPACITY]),
      .rsp_ready  (rsp_ready),
      .adv        (adv),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .occ        (occ)
   );

   // Occupancy never exceeds the store size.
   assert property (@(posedge clock) disable iff (reset)
      occ <= OCC_WIDTH'(CAPACITY))
      else $error("occupancy above capacity");

   // Occupancy moves by at most one per cycle.
   assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (occ == $past(occ)) || (occ == $past(occ) + OCC_WIDTH'(1))
               || (occ + OCC_WIDTH'(1) == $past(occ)))
      else $error("occupancy jumped");

   // A refused insert reports a full store.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == STATUS_FULL))
      |-> (rsp_data.count == COUNT_WIDTH'(CAPACITY)))
      else $error("full status with store not full");

   // A held result freezes the row, so no new item is taken.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("item accepted while result stalled");

endmodule
